[src/three_factor_plasticity_update_core_defines.svh]
// assertion macros used by the checker of this block
`ifndef THREE_FACTOR_PLASTICITY_UPDATE_CORE_DEFINES_SVH
`define THREE_FACTOR_PLASTICITY_UPDATE_CORE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define TFPU_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// implication checked in the same cycle
`define TFPU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[src/tfpu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tfpu_pkg;

	localparam int NUM_CONN_DEF   = 4096;
	localparam int VALUE_BITS_DEF = 16;

	localparam int IDX_W     = 12;
	localparam int DATA_W    = 16;
	localparam int DA_W      = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BASELINE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACE_DECAY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRACE_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MAX   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DECAY = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REPLAY       = 3'd7;

	localparam logic [DATA_W-1:0] RST_BASELINE     = 16'd16384;
	localparam logic [DATA_W-1:0] RST_LEARN_RATE   = 16'd655;
	localparam logic [DATA_W-1:0] RST_TRACE_DECAY  = 16'd62259;
	localparam logic [DATA_W-1:0] RST_TRACE_MAX    = 16'd20480;
	localparam logic [DATA_W-1:0] RST_WEIGHT_MIN   = 16'd0;
	localparam logic [DATA_W-1:0] RST_WEIGHT_MAX   = 16'd12288;
	localparam logic [DATA_W-1:0] RST_WEIGHT_DECAY = 16'd66;

	localparam logic [DA_W-1:0]   DA_ONE     = 16'd32768;
	localparam logic [DATA_W-1:0] ERR_GATE   = 16'd32;
	localparam int                TRACE_GATE = 4;
	localparam int                ONE_Q12    = 4096;
	localparam int                RECIP_SH   = 24;

	typedef struct packed {
		logic [DATA_W-1:0] baseline;
		logic [DATA_W-1:0] learn_rate;
		logic [DATA_W-1:0] trace_decay;
		logic [DATA_W-1:0] trace_max;
		logic [DATA_W-1:0] weight_min;
		logic [DATA_W-1:0] weight_max;
		logic [DATA_W-1:0] weight_decay;
		logic              replay;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             is_d2;
		logic             pre;
		logic             post;
	} item_t;

endpackage

`default_nettype wire

[src/tfpu_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfpu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire              clk,
	input  wire              we,
	input  wire  [AW-1:0]    waddr,
	input  wire  [WIDTH-1:0] wdata,
	input  wire  [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/tfpu_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfpu_cfg_regs import tfpu_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_valid,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [DATA_W-1:0]    cfg_data,
	output logic                 cfg_ready,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.baseline     <= RST_BASELINE;
			cfg_q.learn_rate   <= RST_LEARN_RATE;
			cfg_q.trace_decay  <= RST_TRACE_DECAY;
			cfg_q.trace_max    <= RST_TRACE_MAX;
			cfg_q.weight_min   <= RST_WEIGHT_MIN;
			cfg_q.weight_max   <= RST_WEIGHT_MAX;
			cfg_q.weight_decay <= RST_WEIGHT_DECAY;
			cfg_q.replay       <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASELINE:     cfg_q.baseline     <= cfg_data;
				REG_LEARN_RATE:   cfg_q.learn_rate   <= cfg_data;
				REG_TRACE_DECAY:  cfg_q.trace_decay  <= cfg_data;
				REG_TRACE_MAX:    cfg_q.trace_max    <= cfg_data;
				REG_WEIGHT_MIN:   cfg_q.weight_min   <= cfg_data;
				REG_WEIGHT_MAX:   cfg_q.weight_max   <= cfg_data;
				REG_WEIGHT_DECAY: cfg_q.weight_decay <= cfg_data;
				REG_REPLAY:       cfg_q.replay       <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/tfpu_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfpu_front import tfpu_pkg::*; #(
	parameter int NUM_CONNECTIONS = NUM_CONN_DEF,
	localparam int SLOT_W = $clog2(NUM_CONNECTIONS)
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  wire               hold,
	input  wire  [IDX_W-1:0]  conn_index,
	input  wire               is_d2,
	input  wire               pre_active,
	input  wire               post_fired,
	input  wire  [DA_W-1:0]   dopamine_level,
	input  wire  cfg_t        cfg,
	output logic              valid_s1,
	output item_t             item_s1,
	output logic [DATA_W-1:0] aerr_s1,
	output logic              neg_s1,
	output logic [SLOT_W-1:0] slot
);

	localparam longint RECIP  = (longint'(1) <<< RECIP_SH) / NUM_CONNECTIONS;
	localparam int     PROD_W = IDX_W + RECIP_SH;
	localparam int     NC_W   = $clog2(NUM_CONNECTIONS + 1);
	localparam int     REM_W  = IDX_W + NC_W;
	localparam int     ERR_W  = DATA_W + 2;

	logic [DA_W-1:0]          da_sat;
	logic signed [ERR_W-1:0]  err;
	logic [ERR_W-1:0]         err_mag;
	logic [PROD_W-1:0]        q_prod;
	logic [IDX_W-1:0]         q_s1;
	logic [REM_W-1:0]         rem_raw;
	logic [REM_W-1:0]         rem_adj;

	// dopamine error
	assign da_sat  = (dopamine_level > DA_ONE) ? DA_ONE : dopamine_level;
	assign err     = $signed({2'b00, da_sat}) - $signed({2'b00, cfg.baseline});
	assign err_mag = err[ERR_W-1] ? $unsigned(-err) : $unsigned(err);

	// quotient estimate by reciprocal, never above the true quotient
	assign q_prod = PROD_W'(conn_index) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.idx   <= conn_index;
			item_s1.is_d2 <= is_d2;
			item_s1.pre   <= pre_active;
			item_s1.post  <= post_fired;
			q_s1          <= q_prod[PROD_W-1:RECIP_SH];
			aerr_s1       <= err_mag[DATA_W-1:0];
			neg_s1        <= err[ERR_W-1];
		end
	end

	// remainder with one correction step
	assign rem_raw = REM_W'(item_s1.idx) - REM_W'(q_s1) * REM_W'(NUM_CONNECTIONS);
	assign rem_adj = (rem_raw >= REM_W'(NUM_CONNECTIONS)) ?
		rem_raw - REM_W'(NUM_CONNECTIONS) : rem_raw;
	assign slot    = rem_adj[SLOT_W-1:0];

endmodule

`default_nettype wire

[src/tfpu_update_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfpu_update_pipe import tfpu_pkg::*; #(
	parameter int NUM_CONNECTIONS = NUM_CONN_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int SLOT_W = $clog2(NUM_CONNECTIONS)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  cfg_t            cfg,
	input  wire                   in_valid,
	input  wire  item_t           in_item,
	input  wire  [DATA_W-1:0]     in_aerr,
	input  wire                   in_neg,
	input  wire  [SLOT_W-1:0]     in_slot,
	output logic                  hit,
	input  wire  [VALUE_BITS-1:0] rd_weight,
	input  wire  [VALUE_BITS-1:0] rd_trace,
	output logic                  wr_en,
	output logic [SLOT_W-1:0]     wr_addr,
	output logic [VALUE_BITS-1:0] wr_weight,
	output logic [VALUE_BITS-1:0] wr_trace,
	output logic                  done,
	output logic [IDX_W-1:0]      conn_echo,
	output logic [DATA_W-1:0]     new_weight,
	output logic [DATA_W-1:0]     new_trace
);

	localparam int VW     = VALUE_BITS;
	localparam int XW     = (VW > DATA_W) ? VW : DATA_W;
	localparam int SW     = XW + 3;
	localparam int P1_W   = 2 * DATA_W;
	localparam int PW     = P1_W + VW;
	localparam int MAG_SH = 31;
	localparam int TD_W   = VW + DATA_W;
	localparam int RW     = XW + DATA_W;
	localparam logic [VW-1:0] VMAX    = {VW{1'b1}};
	localparam logic [PW:0]   MAG_RND = (PW+1)'(1) << (MAG_SH - 1);
	localparam logic [RW:0]   DEC_RND = (RW+1)'(1) << (DATA_W - 1);
	localparam logic [XW-1:0] ONE_X   = XW'(ONE_Q12);

	// stage 2: memory data arrives
	logic              v_s2;
	item_t             item_s2;
	logic [SLOT_W-1:0] slot_s2;
	logic              neg_s2;
	logic              gate_e_s2;
	logic [P1_W-1:0]   p1_s2;

	// stage 3
	logic              v_s3;
	logic [IDX_W-1:0]  idx_s3;
	logic [SLOT_W-1:0] slot_s3;
	logic              sub_s3;
	logic              gate_s3;
	logic [P1_W-1:0]   p1_s3;
	logic [VW-1:0]     tr1_s3;
	logic [VW-1:0]     w_s3;

	// stage 4
	logic              v_s4;
	logic [IDX_W-1:0]  idx_s4;
	logic [SLOT_W-1:0] slot_s4;
	logic              sub_s4;
	logic              gate_s4;
	logic [PW-1:0]     prod_s4;
	logic [VW-1:0]     trd_s4;
	logic [VW-1:0]     w_s4;

	// stage 5
	logic              v_s5;
	logic [IDX_W-1:0]  idx_s5;
	logic [SLOT_W-1:0] slot_s5;
	logic [XW-1:0]     w2_s5;
	logic [VW-1:0]     trd_s5;

	// stage 6
	logic              v_s6;
	logic [IDX_W-1:0]  idx_s6;
	logic [SLOT_W-1:0] slot_s6;
	logic [XW-1:0]     w2_s6;
	logic [VW-1:0]     trd_s6;
	logic              dneg_s6;
	logic [RW-1:0]     raw_s6;

	// result beat
	logic              done_q;
	logic [IDX_W-1:0]  conn_echo_q;
	logic [DATA_W-1:0] new_weight_q;
	logic [DATA_W-1:0] new_trace_q;

	logic [XW:0]       rise_t;
	logic [XW:0]       rise_min;
	logic [VW-1:0]     tr_rise;
	logic [VW-1:0]     tr1;
	logic [PW-1:0]     prod;
	logic [TD_W-1:0]   trd_full;
	logic [PW:0]       mag_rnd;
	logic [VW+1:0]     mag;
	logic signed [SW-1:0] w_ext;
	logic signed [SW-1:0] m_ext;
	logic signed [SW-1:0] w_mv;
	logic signed [SW-1:0] w_lo;
	logic signed [SW-1:0] w_hi;
	logic signed [SW-1:0] w_clamp;
	logic [XW-1:0]     w2;
	logic              dneg;
	logic [XW-1:0]     ad;
	logic [RW-1:0]     raw;
	logic [RW:0]       step_rnd;
	logic [XW-1:0]     step;
	logic [XW-1:0]     w4;
	logic [VW-1:0]     w_fin;
	logic [XW-1:0]     w_fin_x;
	logic [XW-1:0]     trd_x;

	// slot still waiting for its write-back
	assign hit = (v_s2 && (slot_s2 == in_slot)) || (v_s3 && (slot_s3 == in_slot)) ||
		(v_s4 && (slot_s4 == in_slot)) || (v_s5 && (slot_s5 == in_slot)) ||
		(v_s6 && (slot_s6 == in_slot));

	// eligibility rise
	assign rise_t   = (XW+1)'(rd_trace) + (XW+1)'(ONE_Q12);
	assign rise_min = (rise_t > (XW+1)'(cfg.trace_max)) ? (XW+1)'(cfg.trace_max) : rise_t;
	assign tr_rise  = (rise_min > (XW+1)'(VMAX)) ? VMAX : rise_min[VW-1:0];
	assign tr1      = (item_s2.pre && item_s2.post) ? tr_rise : rd_trace;

	// learning product and trace decay
	assign prod     = PW'(p1_s3) * PW'(tr1_s3);
	assign trd_full = TD_W'(tr1_s3) * TD_W'(cfg.trace_decay);

	// weight step and clamp
	assign mag_rnd = (PW+1)'(prod_s4) + MAG_RND;
	assign mag     = mag_rnd[PW:MAG_SH];
	assign w_ext   = $signed(SW'(w_s4));
	assign m_ext   = $signed(SW'(mag));
	assign w_mv    = sub_s4 ? (w_ext - m_ext) : (w_ext + m_ext);
	assign w_lo    = $signed(SW'(cfg.weight_min));
	assign w_hi    = $signed(SW'(cfg.weight_max));

	always_comb begin
		if (w_mv < w_lo) begin
			w_clamp = w_lo;
		end else if (w_mv > w_hi) begin
			w_clamp = w_hi;
		end else begin
			w_clamp = w_mv;
		end
	end

	assign w2 = gate_s4 ? w_clamp[XW-1:0] : XW'(w_s4);

	// homeostatic pull toward one
	assign dneg = w2_s5 > ONE_X;
	assign ad   = dneg ? (w2_s5 - ONE_X) : (ONE_X - w2_s5);
	assign raw  = RW'(ad) * RW'(cfg.weight_decay);

	assign step_rnd = (RW+1)'(raw_s6) + DEC_RND;
	assign step     = step_rnd[RW-1:DATA_W];
	assign w4       = cfg.replay ? w2_s6 : (dneg_s6 ? (w2_s6 - step) : (w2_s6 + step));
	assign w_fin    = (w4 > XW'(VMAX)) ? VMAX : w4[VW-1:0];
	assign w_fin_x  = XW'(w_fin);
	assign trd_x    = XW'(trd_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s2   <= in_valid;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			done_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		item_s2   <= in_item;
		slot_s2   <= in_slot;
		neg_s2    <= in_neg;
		gate_e_s2 <= in_aerr > ERR_GATE;
		p1_s2     <= P1_W'(in_aerr) * P1_W'(cfg.learn_rate);

		idx_s3  <= item_s2.idx;
		slot_s3 <= slot_s2;
		sub_s3  <= neg_s2 ^ item_s2.is_d2;
		gate_s3 <= gate_e_s2 && (tr1 > VW'(TRACE_GATE));
		p1_s3   <= p1_s2;
		tr1_s3  <= tr1;
		w_s3    <= rd_weight;

		idx_s4  <= idx_s3;
		slot_s4 <= slot_s3;
		sub_s4  <= sub_s3;
		gate_s4 <= gate_s3;
		prod_s4 <= prod;
		trd_s4  <= trd_full[TD_W-1:DATA_W];
		w_s4    <= w_s3;

		idx_s5  <= idx_s4;
		slot_s5 <= slot_s4;
		w2_s5   <= w2;
		trd_s5  <= trd_s4;

		idx_s6  <= idx_s5;
		slot_s6 <= slot_s5;
		w2_s6   <= w2_s5;
		trd_s6  <= trd_s5;
		dneg_s6 <= dneg;
		raw_s6  <= raw;

		conn_echo_q  <= idx_s6;
		new_weight_q <= w_fin_x[DATA_W-1:0];
		new_trace_q  <= trd_x[DATA_W-1:0];
	end

	assign wr_en     = v_s6;
	assign wr_addr   = slot_s6;
	assign wr_weight = w_fin;
	assign wr_trace  = trd_s6;

	assign done       = done_q;
	assign conn_echo  = conn_echo_q;
	assign new_weight = new_weight_q;
	assign new_trace  = new_trace_q;

endmodule

`default_nettype wire

[src/three_factor_plasticity_update_core.sv]
// Dopamine-gated plasticity engine: one command per connection updates its stored weight and
// eligibility trace and returns both. Commands on distinct connections are taken one per clock
// and each result shows on done for a single cycle, registered behind the write-back stage;
// done cannot be held off, so the receiver must take every beat as it comes. Throughput is set
// by the read-modify-write loop over the weight and trace memories: a command whose connection
// is still being updated by an earlier one waits in the first stage, with busy high, until that
// update is written back. After reset busy stays high while both memories are initialized
// (weights to 1.0, traces to zero); configuration writes are taken at any time and belong to
// periods with no command in flight.
`timescale 1ns / 1ps
`default_nettype none

module three_factor_plasticity_update_core import tfpu_pkg::*; #(
	parameter int NUM_CONNECTIONS = NUM_CONN_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire  [IDX_W-1:0]     conn_index,
	input  wire                  is_d2,
	input  wire                  pre_active,
	input  wire                  post_fired,
	input  wire  [DA_W-1:0]      dopamine_level,
	output logic                 done,
	output logic [IDX_W-1:0]     conn_echo,
	output logic [DATA_W-1:0]    new_weight,
	output logic [DATA_W-1:0]    new_trace,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [DATA_W-1:0]    cfg_data
);

	localparam int SLOT_W = $clog2(NUM_CONNECTIONS);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_CONNECTIONS - 1);
	localparam logic [VALUE_BITS-1:0] W_INIT =
		(((longint'(1) <<< VALUE_BITS) - 1) >= ONE_Q12) ?
		VALUE_BITS'(ONE_Q12) : {VALUE_BITS{1'b1}};

	cfg_t                  cfg;
	logic                  accept;
	logic                  hold;
	logic                  hit;
	logic                  valid_s1;
	item_t                 item_s1;
	logic [DATA_W-1:0]     aerr_s1;
	logic                  neg_s1;
	logic [SLOT_W-1:0]     slot;
	logic [VALUE_BITS-1:0] rd_weight;
	logic [VALUE_BITS-1:0] rd_trace;
	logic                  pipe_wr_en;
	logic [SLOT_W-1:0]     pipe_wr_addr;
	logic [VALUE_BITS-1:0] pipe_wr_weight;
	logic [VALUE_BITS-1:0] pipe_wr_trace;
	logic                  mem_we;
	logic [SLOT_W-1:0]     mem_waddr;
	logic [VALUE_BITS-1:0] mem_wweight;
	logic [VALUE_BITS-1:0] mem_wtrace;
	logic                  clr_q;
	logic [SLOT_W-1:0]     clr_cnt_q;

	assign hold   = valid_s1 && hit;
	assign busy   = clr_q || hold;
	assign accept = start && !busy;

	// memory initialization sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == SLOT_LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign mem_we      = clr_q || pipe_wr_en;
	assign mem_waddr   = clr_q ? clr_cnt_q : pipe_wr_addr;
	assign mem_wweight = clr_q ? W_INIT : pipe_wr_weight;
	assign mem_wtrace  = clr_q ? '0 : pipe_wr_trace;

	tfpu_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	tfpu_front #(
		.NUM_CONNECTIONS (NUM_CONNECTIONS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.hold           (hold),
		.conn_index     (conn_index),
		.is_d2          (is_d2),
		.pre_active     (pre_active),
		.post_fired     (post_fired),
		.dopamine_level (dopamine_level),
		.cfg            (cfg),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1),
		.aerr_s1        (aerr_s1),
		.neg_s1         (neg_s1),
		.slot           (slot)
	);

	tfpu_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (NUM_CONNECTIONS)
	) u_weight_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wweight),
		.raddr (slot),
		.rdata (rd_weight)
	);

	tfpu_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (NUM_CONNECTIONS)
	) u_trace_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wtrace),
		.raddr (slot),
		.rdata (rd_trace)
	);

	tfpu_update_pipe #(
		.NUM_CONNECTIONS (NUM_CONNECTIONS),
		.VALUE_BITS      (VALUE_BITS)
	) u_update_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (valid_s1 && !hit),
		.in_item    (item_s1),
		.in_aerr    (aerr_s1),
		.in_neg     (neg_s1),
		.in_slot    (slot),
		.hit        (hit),
		.rd_weight  (rd_weight),
		.rd_trace   (rd_trace),
		.wr_en      (pipe_wr_en),
		.wr_addr    (pipe_wr_addr),
		.wr_weight  (pipe_wr_weight),
		.wr_trace   (pipe_wr_trace),
		.done       (done),
		.conn_echo  (conn_echo),
		.new_weight (new_weight),
		.new_trace  (new_trace)
	);

endmodule

`default_nettype wire

[src/tfpu_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "three_factor_plasticity_update_core_defines.svh"

module tfpu_chk (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire done,
	input wire cfg_valid,
	input wire cfg_ready
);

	localparam int MAX_INFLIGHT = 7;
	localparam int CNT_W = $clog2(MAX_INFLIGHT + 2);

	logic             beat_in;
	logic [CNT_W-1:0] inflight_q;

	assign beat_in = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (beat_in && !done) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (done && !beat_in) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	`TFPU_ASSERT_ALWAYS(a_inflight_bound, inflight_q <= CNT_W'(MAX_INFLIGHT), "too many items in flight")
	`TFPU_ASSERT_IMPL(a_done_has_item, done, inflight_q != '0, "result beat with no item in flight")
	`TFPU_ASSERT_IMPL(a_busy_after_reset, $past(!arst_n), busy, "busy low right after reset")
	`TFPU_ASSERT_IMPL(a_cfg_always_taken, cfg_valid, cfg_ready, "config beat not taken")

endmodule

bind three_factor_plasticity_update_core tfpu_chk u_tfpu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

[dv/plasticity_monitor.sv]
`timescale 1ns / 1ps

module plasticity_monitor import tfpu_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire                  busy,
	input  wire  [IDX_W-1:0]     conn_index,
	input  wire                  is_d2,
	input  wire                  pre_active,
	input  wire                  post_fired,
	input  wire  [DA_W-1:0]      dopamine_level,
	input  wire                  done,
	input  wire  [IDX_W-1:0]     conn_echo,
	input  wire  [DATA_W-1:0]    new_weight,
	input  wire  [DATA_W-1:0]    new_trace,
	input  wire                  cfg_valid,
	input  wire                  cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [DATA_W-1:0]    cfg_data,
	output int                   failures,
	output int                   pending,
	output int                   checked
);

	localparam longint UNITY      = 4096;
	localparam longint DA_FULL    = 32768;
	localparam longint ERR_BAND   = 32;
	localparam longint TRACE_BAND = 4;
	localparam longint VAL_CEIL   = 65535;
	localparam longint HALF_Q31   = 1073741824;
	localparam longint HALF_Q16   = 32768;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] weight;
		logic [DATA_W-1:0] trace;
	} synapse_update_t;

	cfg_t              cfg;
	logic [DATA_W-1:0] weight_mem [NUM_CONN_DEF];
	logic [DATA_W-1:0] trace_mem  [NUM_CONN_DEF];
	synapse_update_t   pending_updates [$];

	function automatic longint clip_value(input longint v);
		if (v < 0)
			return 0;
		if (v > VAL_CEIL)
			return VAL_CEIL;
		return v;
	endfunction

	// returns {weight, trace} after one learning step on a connection
	function automatic logic [2*DATA_W-1:0] next_synapse_state(
		input cfg_t c,
		input logic [DATA_W-1:0] w_old,
		input logic [DATA_W-1:0] tr_old,
		input logic d2,
		input logic pre,
		input logic post,
		input logic [DA_W-1:0] da_in
	);
		longint w, tr, da, err, aerr, mag, wdelta, awdelta, pull, prod;
		longint wmin, wmax;
		logic neg;
		w = {48'd0, w_old};
		tr = {48'd0, tr_old};
		da = {48'd0, da_in};
		wmin = {48'd0, c.weight_min};
		wmax = {48'd0, c.weight_max};
		if (da > DA_FULL)
			da = DA_FULL;
		err = da - {48'd0, c.baseline};
		aerr = (err < 0) ? -err : err;

		if (pre && post) begin
			tr = tr + UNITY;
			if (tr > {48'd0, c.trace_max})
				tr = {48'd0, c.trace_max};
			tr = clip_value(tr);
		end

		if (aerr > ERR_BAND && tr > TRACE_BAND) begin
			prod = {48'd0, c.learn_rate} * aerr * tr;
			mag = (prod + HALF_Q31) >>> 31;
			neg = (err < 0) != d2;
			w = neg ? w - mag : w + mag;
			if (w < wmin)
				w = wmin;
			else if (w > wmax)
				w = wmax;
		end

		tr = (tr * {48'd0, c.trace_decay}) >>> 16;

		if (!c.replay && c.weight_decay != '0) begin
			wdelta = UNITY - w;
			awdelta = (wdelta < 0) ? -wdelta : wdelta;
			pull = ({48'd0, c.weight_decay} * awdelta + HALF_Q16) >>> 16;
			w = (wdelta < 0) ? w - pull : w + pull;
		end

		w = clip_value(w);
		tr = clip_value(tr);
		return {w[DATA_W-1:0], tr[DATA_W-1:0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [2*DATA_W-1:0] nxt;
		synapse_update_t     want;
		int                  errs;
		if (!arst_n) begin
			for (int i = 0; i < NUM_CONN_DEF; i++) begin
				weight_mem[i] = ONE_Q12[DATA_W-1:0];
				trace_mem[i] = '0;
			end
			cfg.baseline = RST_BASELINE;
			cfg.learn_rate = RST_LEARN_RATE;
			cfg.trace_decay = RST_TRACE_DECAY;
			cfg.trace_max = RST_TRACE_MAX;
			cfg.weight_min = RST_WEIGHT_MIN;
			cfg.weight_max = RST_WEIGHT_MAX;
			cfg.weight_decay = RST_WEIGHT_DECAY;
			cfg.replay = 1'b0;
			pending_updates.delete();
			failures <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			errs = 0;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BASELINE:     cfg.baseline = cfg_data;
					REG_LEARN_RATE:   cfg.learn_rate = cfg_data;
					REG_TRACE_DECAY:  cfg.trace_decay = cfg_data;
					REG_TRACE_MAX:    cfg.trace_max = cfg_data;
					REG_WEIGHT_MIN:   cfg.weight_min = cfg_data;
					REG_WEIGHT_MAX:   cfg.weight_max = cfg_data;
					REG_WEIGHT_DECAY: cfg.weight_decay = cfg_data;
					REG_REPLAY:       cfg.replay = cfg_data[0];
					default: ;
				endcase
			end

			if (start && !busy) begin
				nxt = next_synapse_state(cfg, weight_mem[conn_index], trace_mem[conn_index],
					is_d2, pre_active, post_fired, dopamine_level);
				weight_mem[conn_index] = nxt[2*DATA_W-1:DATA_W];
				trace_mem[conn_index] = nxt[DATA_W-1:0];
				want.idx = conn_index;
				want.weight = nxt[2*DATA_W-1:DATA_W];
				want.trace = nxt[DATA_W-1:0];
				pending_updates = {pending_updates, want};
			end

			if (done) begin
				if (pending_updates.size() == 0) begin
					$error("unexpected result beat: conn_echo %0d new_weight %0d new_trace %0d",
						conn_echo, new_weight, new_trace);
					errs++;
				end else begin
					want = pending_updates.pop_front();
					if (conn_echo !== want.idx) begin
						$error("conn_echo mismatch: expected %0d, got %0d", want.idx, conn_echo);
						errs++;
					end
					if (new_weight !== want.weight) begin
						$error("new_weight mismatch: expected %0d, got %0d",
							want.weight, new_weight);
						errs++;
					end
					if (new_trace !== want.trace) begin
						$error("new_trace mismatch: expected %0d, got %0d", want.trace, new_trace);
						errs++;
					end
					checked <= checked + 1;
				end
			end

			failures <= failures + errs;
			pending <= pending_updates.size();
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import tfpu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 100;
	localparam int NUM_PLANS   = 7;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [IDX_W-1:0]     conn_index;
	logic                 is_d2;
	logic                 pre_active;
	logic                 post_fired;
	logic [DA_W-1:0]      dopamine_level;
	logic                 done;
	logic [IDX_W-1:0]     conn_echo;
	logic [DATA_W-1:0]    new_weight;
	logic [DATA_W-1:0]    new_trace;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	int failures;
	int pending;
	int checked;
	int cycles;
	int cmds_sent;
	int reg_writes;
	int settings_run;

	logic [IDX_W-1:0] conn_pool [8];

	three_factor_plasticity_update_core dut (.*);

	plasticity_monitor u_monitor (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_cmd(
		input logic [IDX_W-1:0] idx,
		input logic d2,
		input logic pre,
		input logic post,
		input logic [DA_W-1:0] da,
		input int gap
	);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		conn_index <= idx;
		is_d2 <= d2;
		pre_active <= pre;
		post_fired <= post;
		dopamine_level <= da;
		do @(posedge clk); while (busy);
		cmds_sent++;
	endtask

	// hold off new beats until every outstanding update has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic apply_setting(input cfg_t s);
		logic [DATA_W-1:0] vals [8];
		drain();
		repeat (10) @(posedge clk);
		vals[REG_BASELINE] = s.baseline;
		vals[REG_LEARN_RATE] = s.learn_rate;
		vals[REG_TRACE_DECAY] = s.trace_decay;
		vals[REG_TRACE_MAX] = s.trace_max;
		vals[REG_WEIGHT_MIN] = s.weight_min;
		vals[REG_WEIGHT_MAX] = s.weight_max;
		vals[REG_WEIGHT_DECAY] = s.weight_decay;
		vals[REG_REPLAY] = {{(DATA_W-1){1'b0}}, s.replay};
		cfg_valid <= 1'b1;
		for (int i = 0; i < 8; i++) begin
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			reg_writes++;
		end
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [DA_W-1:0] pick_dopamine(input logic [DATA_W-1:0] base);
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 8)
			v = 0;
		else if (r < 16)
			v = 32768;
		else if (r < 24)
			v = $urandom_range(32769, 65535);
		else if (r < 50) begin
			v = int'(base) + int'($urandom_range(0, 80)) - 40;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
		end else
			v = $urandom_range(0, 32768);
		return DA_W'(v);
	endfunction

	function automatic cfg_t random_setting();
		cfg_t s;
		s.baseline = DATA_W'($urandom_range(0, 32768));
		s.learn_rate = DATA_W'($urandom);
		s.trace_decay = DATA_W'($urandom);
		s.trace_max = DATA_W'($urandom);
		s.weight_min = DATA_W'($urandom);
		s.weight_max = DATA_W'($urandom);
		s.weight_decay = DATA_W'($urandom);
		s.replay = 1'($urandom);
		return s;
	endfunction

	task automatic random_cmd(input cfg_t s, input bit burst);
		logic [IDX_W-1:0] idx;
		logic             pre;
		logic             post;
		if ($urandom_range(0, 99) < 80)
			idx = conn_pool[$urandom_range(0, 7)];
		else
			idx = IDX_W'($urandom);
		if ($urandom_range(0, 99) < 55)
			{pre, post} = 2'b11;
		else
			{pre, post} = 2'($urandom);
		send_cmd(idx, 1'($urandom), pre, post, pick_dopamine(s.baseline),
			burst ? 0 : pick_gap());
	endtask

	initial begin
		cfg_t plan [NUM_PLANS];
		cfg_t corner;
		bit   burst;

		arst_n <= 1'b0;
		start <= 1'b0;
		conn_index <= '0;
		is_d2 <= 1'b0;
		pre_active <= 1'b0;
		post_fired <= 1'b0;
		dopamine_level <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: extremes of dopamine, both pathways, gate edges
		send_cmd(12'h000, 1'b0, 1'b1, 1'b1, 16'd32768, 0);
		send_cmd(12'h000, 1'b1, 1'b1, 1'b1, 16'd0, 0);
		send_cmd(12'hFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 0);
		send_cmd(12'hFFF, 1'b0, 1'b1, 1'b1, RST_BASELINE + 16'd32, 2);
		send_cmd(12'hFFF, 1'b0, 1'b0, 1'b0, RST_BASELINE + 16'd33, 0);
		send_cmd(12'hAAA, 1'b0, 1'b1, 1'b0, 16'd32768, 0);
		send_cmd(12'h555, 1'b1, 1'b0, 1'b1, 16'd0, 1);
		// trace pumped into its limit
		repeat (6) send_cmd(12'h003, 1'b0, 1'b1, 1'b1, 16'd32768, 0);
		send_cmd(12'h003, 1'b1, 1'b0, 1'b0, 16'd0, 0);

		// clamp limits swapped, trace limit below the stored trace
		corner = '{baseline: 16'd0, learn_rate: 16'hFFFF, trace_decay: 16'hFFFF,
			trace_max: 16'd2048, weight_min: 16'd9000, weight_max: 16'd3000,
			weight_decay: 16'd0, replay: 1'b1};
		apply_setting(corner);
		send_cmd(12'h003, 1'b0, 1'b1, 1'b1, 16'd32768, 0);
		send_cmd(12'h003, 1'b1, 1'b1, 1'b1, 16'd100, 0);
		send_cmd(12'h007, 1'b0, 1'b0, 1'b0, 16'd32768, 0);
		send_cmd(12'h000, 1'b0, 1'b1, 1'b1, 16'd0, 0);

		plan[0] = '{baseline: RST_BASELINE, learn_rate: RST_LEARN_RATE,
			trace_decay: RST_TRACE_DECAY, trace_max: RST_TRACE_MAX,
			weight_min: RST_WEIGHT_MIN, weight_max: RST_WEIGHT_MAX,
			weight_decay: RST_WEIGHT_DECAY, replay: 1'b0};
		plan[1] = '{baseline: 16'd32768, learn_rate: 16'hFFFF, trace_decay: 16'hFFFF,
			trace_max: 16'hFFFF, weight_min: 16'd0, weight_max: 16'hFFFF,
			weight_decay: 16'hFFFF, replay: 1'b0};
		plan[2] = '{baseline: 16'd0, learn_rate: 16'd0, trace_decay: 16'd0,
			trace_max: 16'd0, weight_min: 16'd0, weight_max: 16'd0,
			weight_decay: 16'd0, replay: 1'b1};
		// saturating traces and weights
		plan[3] = '{baseline: 16'd0, learn_rate: 16'hFFFF, trace_decay: 16'hFFFF,
			trace_max: 16'hFFFF, weight_min: 16'd0, weight_max: 16'hFFFF,
			weight_decay: 16'd0, replay: 1'b1};
		for (int k = 4; k < NUM_PLANS; k++)
			plan[k] = random_setting();

		for (int p = 0; p < NUM_PLANS; p++) begin
			apply_setting(plan[p]);
			foreach (conn_pool[k])
				conn_pool[k] = IDX_W'($urandom);
			burst = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 25 == 0)
					burst = ($urandom_range(0, 2) == 0);
				if (n == PHASE_ITEMS / 2)
					drain();
				random_cmd(plan[p], burst);
			end
		end

		drain();
		repeat (20) @(posedge clk);

		$display("sent %0d commands under %0d register settings (%0d register writes)",
			cmds_sent, settings_run + 1, reg_writes);
		$display("compared %0d result beats, %0d mismatches", checked, failures);
		if (failures == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/tfpu_pkg.sv
src/tfpu_ram.sv
src/tfpu_cfg_regs.sv
src/tfpu_front.sv
src/tfpu_update_pipe.sv
src/three_factor_plasticity_update_core.sv
src/tfpu_chk.sv
dv/plasticity_monitor.sv
dv/tb.sv
